// ===== src/tct_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package tct_pkg;
	localparam int MaxContacts = 10;
	localparam int SlotW = (MaxContacts > 1) ? $clog2(MaxContacts) : 1;
	localparam int CntW = $clog2(MaxContacts + 1);
	// one contact row: id, x, y, dx, dy
	localparam int RowW = 160;

	typedef enum logic [2:0] {
		ACT_FRAME = 3'd0,
		ACT_DOWN  = 3'd1,
		ACT_MOVE  = 3'd2,
		ACT_UP    = 3'd3,
		ACT_QSLOT = 3'd4,
		ACT_QID   = 3'd5
	} action_t;

	typedef enum logic [1:0] {
		KIND_ACK     = 2'd0,
		KIND_RELEASE = 2'd1,
		KIND_REPORT  = 2'd2,
		KIND_DROP    = 2'd3
	} kind_t;
endpackage
`default_nettype wire

// ===== src/tct_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tct_ram #(
	parameter int Width = 32,
	parameter int Depth = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	output logic      [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== src/touch_contact_tracker_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// touch contact tracker: contact rows and previous-frame ids live in two synchronous rams
// the work per transaction grows with the slots walked (search, compaction, frame copy,
// snapshot scan); the worst case is an id query hitting the last slot with a full snapshot
// one transaction at a time: start is taken only in idle; the strobe lasts one cycle, no stall
// reset (arst_n low) empties both tables at once; ram contents are not cleared
module touch_contact_tracker_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [2:0]  action,
	input  wire logic [31:0] contact_id,
	input  wire logic [31:0] pos_x,
	input  wire logic [31:0] pos_y,
	input  wire logic [31:0] delta_x,
	input  wire logic [31:0] delta_y,
	input  wire logic [3:0]  slot_index,
	output logic             result_valid,
	output logic [1:0]       result_kind,
	output logic             found,
	output logic [31:0]      report_id,
	output logic [31:0]      report_x,
	output logic [31:0]      report_y,
	output logic [31:0]      report_dx,
	output logic [31:0]      report_dy,
	output logic             newly_pressed,
	output logic [3:0]       active_count
);
	localparam int SW = tct_pkg::SlotW;
	localparam int CW = tct_pkg::CntW;
	localparam int RW = tct_pkg::RowW;
	localparam int MC = tct_pkg::MaxContacts;

	typedef enum logic [3:0] {
		ST_IDLE, ST_SRCH, ST_DISPATCH, ST_SHIFT, ST_FRAME, ST_QREAD, ST_PSCAN, ST_DONE
	} state_t;

	state_t state_q;
	logic [2:0]  act_q;
	logic [31:0] id_q, px_q, py_q, dx_q, dy_q;
	logic [3:0]  slot_q;
	logic [CW-1:0] cnt_q, pcnt_q;
	logic [CW-1:0] idx_q;       // walk index
	logic          rd_pend_q;   // ram read data for idx_q-1 valid this cycle
	logic          hit_q;
	logic [SW-1:0] hit_slot_q;
	logic [RW-1:0] row_q;       // row being updated, reported or released
	logic          np_q;

	// contact row ram
	logic          c_we;
	logic [SW-1:0] c_waddr, c_raddr;
	logic [RW-1:0] c_wdata, c_rdata;
	// snapshot ram
	logic          p_we;
	logic [SW-1:0] p_waddr, p_raddr;
	logic [31:0]   p_wdata, p_rdata;

	tct_ram #(.Width(RW), .Depth(MC)) u_rows (
		.clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
		.raddr(c_raddr), .rdata(c_rdata)
	);
	tct_ram #(.Width(32), .Depth(MC)) u_prev (
		.clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
		.raddr(p_raddr), .rdata(p_rdata)
	);

	logic [CW-1:0] idx_m1;
	assign idx_m1 = idx_q - CW'(1);

	// saturating accumulate
	function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {a[31], a} + {b[31], b};
		if (s[32] != s[31]) begin
			return s[32] ? 32'h8000_0000 : 32'h7fff_ffff;
		end
		return s[31:0];
	endfunction

	// ram port steering
	always_comb begin
		c_we = 1'b0;
		c_waddr = hit_slot_q;
		c_wdata = c_rdata;
		c_raddr = idx_q[SW-1:0];
		p_we = 1'b0;
		p_waddr = idx_m1[SW-1:0];
		p_wdata = c_rdata[159:128];
		p_raddr = idx_q[SW-1:0];
		case (state_q)
			ST_DISPATCH: begin
				if ((act_q == tct_pkg::ACT_DOWN || act_q == tct_pkg::ACT_MOVE)) begin
					if (hit_q) begin
						c_we = 1'b1;
						c_waddr = hit_slot_q;
						c_wdata = {row_q[159:128], px_q, py_q,
							(act_q == tct_pkg::ACT_MOVE) ? sat_add(row_q[63:32], dx_q)
								: row_q[63:32],
							(act_q == tct_pkg::ACT_MOVE) ? sat_add(row_q[31:0], dy_q)
								: row_q[31:0]};
					end else if (cnt_q < CW'(MC)) begin
						c_we = 1'b1;
						c_waddr = cnt_q[SW-1:0];
						c_wdata = {id_q, px_q, py_q,
							(act_q == tct_pkg::ACT_MOVE) ? dx_q : 32'd0,
							(act_q == tct_pkg::ACT_MOVE) ? dy_q : 32'd0};
					end
				end
			end
			ST_SHIFT: begin
				// idx_q-1 read arrived: write it one slot down
				c_we = rd_pend_q;
				c_waddr = idx_m1[SW-1:0] - SW'(1);
				c_wdata = c_rdata;
			end
			ST_FRAME: begin
				c_we = rd_pend_q;
				c_waddr = idx_m1[SW-1:0];
				c_wdata = {c_rdata[159:64], 64'd0};
				p_we = rd_pend_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy <= 1'b0;
			result_valid <= 1'b0;
			cnt_q <= '0;
			pcnt_q <= '0;
			idx_q <= '0;
			rd_pend_q <= 1'b0;
			hit_q <= 1'b0;
		end else begin
			result_valid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						busy <= 1'b1;
						act_q <= action;
						id_q <= contact_id;
						px_q <= pos_x;
						py_q <= pos_y;
						dx_q <= delta_x;
						dy_q <= delta_y;
						slot_q <= slot_index;
						idx_q <= '0;
						rd_pend_q <= 1'b0;
						hit_q <= 1'b0;
						np_q <= 1'b1;
						state_q <= ST_SRCH;
					end
				end
				ST_SRCH: begin
					// id search, one row per cycle; frame and slot query skip it
					if (act_q == tct_pkg::ACT_FRAME) begin
						idx_q <= '0;
						rd_pend_q <= 1'b0;
						state_q <= ST_FRAME;
					end else if (act_q == tct_pkg::ACT_QSLOT) begin
						// put the slot on the read address ahead of the read cycle
						idx_q <= CW'(slot_q);
						state_q <= ST_QREAD;
						rd_pend_q <= 1'b0;
					end else if (rd_pend_q && c_rdata[159:128] == id_q) begin
						hit_q <= 1'b1;
						hit_slot_q <= idx_m1[SW-1:0];
						row_q <= c_rdata;
						idx_q <= idx_q;
						state_q <= ST_DISPATCH;
						rd_pend_q <= 1'b0;
					end else if (idx_q >= cnt_q) begin
						state_q <= ST_DISPATCH;
						rd_pend_q <= 1'b0;
					end else begin
						idx_q <= idx_q + CW'(1);
						rd_pend_q <= 1'b1;
					end
				end
				ST_DISPATCH: begin
					result_kind <= tct_pkg::KIND_ACK;
					found <= 1'b0;
					report_id <= '0;
					report_x <= '0;
					report_y <= '0;
					report_dx <= '0;
					report_dy <= '0;
					newly_pressed <= 1'b0;
					state_q <= ST_DONE;
					case (act_q)
						tct_pkg::ACT_DOWN, tct_pkg::ACT_MOVE: begin
							if (!hit_q) begin
								if (cnt_q < CW'(MC)) begin
									cnt_q <= cnt_q + CW'(1);
								end else begin
									result_kind <= tct_pkg::KIND_DROP;
								end
							end
						end
						tct_pkg::ACT_UP: begin
							result_kind <= tct_pkg::KIND_RELEASE;
							report_id <= id_q;
							report_x <= px_q;
							report_y <= py_q;
							if (hit_q) begin
								found <= 1'b1;
								report_dx <= row_q[63:32];
								report_dy <= row_q[31:0];
								// idx_q is hit_slot+1: start shifting from there
								rd_pend_q <= 1'b0;
								state_q <= ST_SHIFT;
							end
						end
						tct_pkg::ACT_QID: begin
							result_kind <= tct_pkg::KIND_REPORT;
							if (hit_q) begin
								idx_q <= '0;
								rd_pend_q <= 1'b0;
								state_q <= ST_PSCAN;
							end
						end
						default: ;
					endcase
				end
				ST_SHIFT: begin
					// read idx_q, write previous read to idx_q-2
					if (idx_q >= cnt_q) begin
						if (!rd_pend_q || idx_q > cnt_q) begin
							cnt_q <= cnt_q - CW'(1);
							state_q <= ST_DONE;
						end
						rd_pend_q <= 1'b0;
						idx_q <= idx_q + CW'(1);
					end else begin
						idx_q <= idx_q + CW'(1);
						rd_pend_q <= 1'b1;
					end
				end
				ST_FRAME: begin
					if (idx_q >= cnt_q && !(rd_pend_q && idx_q == cnt_q)) begin
						pcnt_q <= cnt_q;
						result_kind <= tct_pkg::KIND_ACK;
						found <= 1'b0;
						report_id <= '0;
						report_x <= '0;
						report_y <= '0;
						report_dx <= '0;
						report_dy <= '0;
						newly_pressed <= 1'b0;
						state_q <= ST_DONE;
					end else begin
						rd_pend_q <= idx_q < cnt_q;
						idx_q <= idx_q + CW'(1);
					end
				end
				ST_QREAD: begin
					// slot query: one read, then the snapshot scan; an out-of-range slot ends with found low
					result_kind <= tct_pkg::KIND_REPORT;
					found <= 1'b0;
					report_id <= '0;
					report_x <= '0;
					report_y <= '0;
					report_dx <= '0;
					report_dy <= '0;
					newly_pressed <= 1'b0;
					if ({1'b0, slot_q} >= {1'b0, 4'(cnt_q)} || CW'(slot_q) >= cnt_q
						|| 5'(slot_q) >= 5'(MC)) begin
						state_q <= ST_DONE;
					end else if (!rd_pend_q) begin
						idx_q <= CW'(slot_q);
						rd_pend_q <= 1'b1;
						state_q <= ST_QREAD;
					end else begin
						row_q <= c_rdata;
						hit_q <= 1'b1;
						idx_q <= '0;
						rd_pend_q <= 1'b0;
						state_q <= ST_PSCAN;
					end
				end
				ST_PSCAN: begin
					if (rd_pend_q && p_rdata == row_q[159:128]) begin
						np_q <= 1'b0;
					end
					if (idx_q >= pcnt_q && !(rd_pend_q && idx_q == pcnt_q && 1'b0)) begin
						if (!rd_pend_q || idx_q > pcnt_q || 1'b1) begin
							found <= 1'b1;
							report_id <= row_q[159:128];
							report_x <= row_q[127:96];
							report_y <= row_q[95:64];
							report_dx <= row_q[63:32];
							report_dy <= row_q[31:0];
							newly_pressed <= np_q
								&& !(rd_pend_q && p_rdata == row_q[159:128]);
							state_q <= ST_DONE;
						end
					end else begin
						rd_pend_q <= 1'b1;
						idx_q <= idx_q + CW'(1);
					end
				end
				ST_DONE: begin
					result_valid <= 1'b1;
					active_count <= 4'(cnt_q);
					busy <= 1'b0;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire
